FILE: hw/rtl/allocation_tracking_table_assert.svh
// assertion macros for the allocation tracking table checker
`ifndef ALLOCATION_TRACKING_TABLE_ASSERT_SVH
`define ALLOCATION_TRACKING_TABLE_ASSERT_SVH

// same-cycle implication
`define ATT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("att check failed");

// next-cycle implication
`define ATT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("att check failed");

`endif

FILE: hw/rtl/att_pkg.sv
package att_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int LIVE_W        = 11;

  localparam logic [1:0] ACT_ALLOC   = 2'd0;
  localparam logic [1:0] ACT_FREE    = 2'd1;
  localparam logic [1:0] ACT_ENABLE  = 2'd2;
  localparam logic [1:0] ACT_DISABLE = 2'd3;

  localparam logic [2:0] STAT_RECORDED  = 3'd0;
  localparam logic [2:0] STAT_REMOVED   = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_MODE      = 3'd4;

  localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [LIVE_W-1:0] FULL_LIVE  = LIVE_W'(TABLE_ENTRIES);

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] block_address;
    logic [31:0] block_size;
    logic [63:0] caller_address;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [LIVE_W-1:0] live_count;
  } out_word_t;

  typedef struct packed {
    logic [63:0] address;
    logic [31:0] size;
    logic [63:0] caller;
  } entry_t;

  typedef struct packed {
    logic             wr;
    logic             step;
    logic             drop;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] last_idx;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/att_cell.sv
module att_cell (
  input  logic                     clk,
  input  logic [att_pkg::IDX_W-1:0] cell_idx,
  input  att_pkg::cell_ctl_t       ctl,
  input  att_pkg::entry_t          wr_entry,
  input  att_pkg::entry_t          next_entry,
  input  att_pkg::entry_t          head_entry,
  output att_pkg::entry_t          entry
);
  import att_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    priority if (ctl.wr && (cell_idx == ctl.wr_idx)) begin
      entry_nxt = wr_entry;
    end else if (ctl.step && (cell_idx < ctl.last_idx)) begin
      entry_nxt = next_entry;
    end else if (ctl.step && (cell_idx == ctl.last_idx) && !ctl.drop) begin
      // window wraps: head word moves to the tail
      entry_nxt = head_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: hw/rtl/att_ctrl.sv
module att_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  att_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output att_pkg::out_word_t out_data,
  input  att_pkg::entry_t    head_entry,
  output att_pkg::cell_ctl_t ctl,
  output att_pkg::entry_t    wr_entry
);
  import att_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             tracking_r, tracking_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic [2:0]       status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;
  in_word_t         item_r;

  logic [CNT_W-1:0] last_full;
  logic             hit;
  logic             scan_end;

  assign last_full = count_r - CNT_W'(1);
  assign hit       = (head_entry.address == item_r.block_address);
  assign scan_end  = (CNT_W'(scan_r) == last_full);

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign wr_entry.address = item_r.block_address;
  assign wr_entry.size    = item_r.block_size;
  assign wr_entry.caller  = item_r.caller_address;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    tracking_nxt  = tracking_r;
    scan_nxt      = scan_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    ctl.wr_idx    = count_r[IDX_W-1:0];
    ctl.last_idx  = last_full[IDX_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt  = ST_DONE;
        status_nxt = STAT_MODE;
        unique case (item_r.action)
          ACT_ALLOC: begin
            if (tracking_r) begin
              if (count_r == FULL_COUNT) begin
                status_nxt = STAT_FULL;
              end else begin
                ctl.wr     = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
                status_nxt = STAT_RECORDED;
              end
            end
          end
          ACT_FREE: begin
            if (tracking_r) begin
              if (count_r == '0) begin
                status_nxt = STAT_NOT_FOUND;
              end else begin
                scan_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
          end
          ACT_ENABLE: begin
            count_nxt    = '0;
            tracking_nxt = 1'b1;
          end
          ACT_DISABLE: begin
            tracking_nxt = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        ctl.step = 1'b1;
        ctl.drop = hit;
        priority if (hit) begin
          count_nxt  = last_full;
          status_nxt = STAT_REMOVED;
          state_nxt  = ST_DONE;
        end else if (scan_end) begin
          status_nxt = STAT_NOT_FOUND;
          state_nxt  = ST_DONE;
        end else begin
          scan_nxt = scan_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.live_count = LIVE_W'(count_r);
          state_nxt               = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      tracking_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tracking_r  <= tracking_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r     <= scan_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
  end

endmodule

FILE: hw/rtl/allocation_tracking_table.sv
// one word at a time: alloc, enable and disable pass through the EXEC and DONE states, then the output register
// a tracked free on a non-empty table adds SCAN over k live entries (1 to TABLE_ENTRIES), one cell shift a cycle
// the next word is taken in the cycle after the result is loaded into the output register
// reset (synchronous, rst_n low) empties the table and turns tracking off
// no clearing pass: entry cells are only read below the live count
module allocation_tracking_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  att_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output att_pkg::out_word_t out_data
);
  import att_pkg::*;

  cell_ctl_t ctl;
  entry_t    wr_entry;
  entry_t    cell_q [TABLE_ENTRIES];

  att_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .head_entry (cell_q[0]),
    .ctl        (ctl),
    .wr_entry   (wr_entry)
  );

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
    att_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(gi)),
      .ctl        (ctl),
      .wr_entry   (wr_entry),
      .next_entry (cell_q[(gi + 1) % TABLE_ENTRIES]),
      .head_entry (cell_q[0]),
      .entry      (cell_q[gi])
    );
  end

endmodule

FILE: hw/rtl/att_checker.sv
`include "allocation_tracking_table_assert.svh"

module att_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input att_pkg::out_word_t out_data
);
  import att_pkg::*;

  `ATT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `ATT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)
  `ATT_ASSERT_NOW(a_full_count, clk, rst_n, out_valid && (out_data.status == STAT_FULL), out_data.live_count == FULL_LIVE)
  `ATT_ASSERT_NOW(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind allocation_tracking_table att_checker u_att_checker (.*);

FILE: dv/allocation_tracking_table_test.sv
`timescale 1ns / 1ps

module allocation_tracking_table_test;
  import att_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned PHASE_WORDS  = 125;
  localparam int unsigned SETTLE_TICKS = TABLE_ENTRIES + 16;
  localparam int          DIRECTED_FILL = 40;

  class live_alloc_scoreboard;
    logic [63:0]   addr_tbl [TABLE_ENTRIES];
    int unsigned   live;
    bit            tracking;
    out_word_t     pending_status [$];
    int unsigned   errors;

    function new();
      live = 0;
      tracking = 1'b0;
      errors = 0;
    endfunction

    function int unsigned pending_count();
      return pending_status.size();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // update the live set for one accepted word and queue its status
    function void note_action(in_word_t w);
      out_word_t   exp;
      bit          found;
      exp.status = STAT_MODE;
      case (w.action)
        ACT_ALLOC: begin
          if (tracking) begin
            if (live >= TABLE_ENTRIES) begin
              exp.status = STAT_FULL;
            end else begin
              addr_tbl[live] = w.block_address;
              live++;
              exp.status = STAT_RECORDED;
            end
          end
        end
        ACT_FREE: begin
          if (tracking) begin
            found = 1'b0;
            for (int unsigned k = 0; k < live && !found; k++) begin
              if (addr_tbl[k] == w.block_address) begin
                addr_tbl[k] = addr_tbl[live - 1];
                found = 1'b1;
              end
            end
            if (found) begin
              live--;
              exp.status = STAT_REMOVED;
            end else begin
              exp.status = STAT_NOT_FOUND;
            end
          end
        end
        ACT_ENABLE: begin
          live = 0;
          tracking = 1'b1;
        end
        ACT_DISABLE: begin
          tracking = 1'b0;
        end
      endcase
      exp.live_count = LIVE_W'(live);
      pending_status.push_back(exp);
    endfunction

    task check_status(out_word_t got);
      out_word_t exp;
      if (pending_status.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        exp = pending_status.pop_front();
        if (got.status !== exp.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, exp.status));
        if (got.live_count !== exp.live_count)
          report_mismatch($sformatf("live_count got %0d want %0d",
                                    got.live_count, exp.live_count));
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  live_alloc_scoreboard sb = new();

  allocation_tracking_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_status(out_data);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_word_t word_of(logic [1:0] act, logic [63:0] a,
                                       logic [31:0] s, logic [63:0] c);
    in_word_t w;
    w.action = act;
    w.block_address = a;
    w.block_size = s;
    w.caller_address = c;
    return w;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_action(w);
    @(negedge clk);
  endtask

  task automatic send_action(logic [1:0] act, logic [63:0] a);
    send_word(word_of(act, a, $urandom, rand64()));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    logic [63:0] ones;
    logic [63:0] first_addr;
    logic [63:0] last_addr;
    ones = '1;
    // tracking off
    send_word(word_of(ACT_ALLOC, ones, '1, ones));
    send_action(ACT_FREE, ones);
    send_action(ACT_DISABLE, rand64());
    send_action(ACT_ENABLE, rand64());
    send_action(ACT_FREE, rand64());
    send_word(word_of(ACT_ALLOC, ones, '1, ones));
    send_word(word_of(ACT_ALLOC, '0, '0, '0));
    send_action(ACT_ALLOC, ones);
    send_action(ACT_ALLOC, 64'h5555_5555_5555_5555);
    // duplicate address, lowest slot goes first
    send_action(ACT_FREE, ones);
    send_action(ACT_FREE, ones);
    send_action(ACT_FREE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_action(ACT_FREE, '0);
    send_action(ACT_ENABLE, rand64());
    send_action(ACT_ALLOC, 64'hAAAA_AAAA_AAAA_AAAA);
    send_action(ACT_DISABLE, rand64());
    send_action(ACT_ALLOC, rand64());
    send_action(ACT_FREE, 64'hAAAA_AAAA_AAAA_AAAA);
    send_action(ACT_ENABLE, rand64());
    // fill part of the table
    first_addr = rand64();
    send_action(ACT_ALLOC, first_addr);
    last_addr = first_addr;
    for (int i = 1; i < DIRECTED_FILL; i++) begin
      last_addr = rand64();
      send_action(ACT_ALLOC, last_addr);
    end
    send_action(ACT_ALLOC, rand64());
    send_word(word_of(ACT_ALLOC, ones, '1, ones));
    send_action(ACT_FREE, last_addr);
    send_action(ACT_ALLOC, rand64());
    send_action(ACT_FREE, first_addr);
    send_action(ACT_ALLOC, ones);
    send_action(ACT_FREE, rand64());
    send_action(ACT_ENABLE, rand64());
  endtask

  task automatic run_random(int unsigned n_words);
    int unsigned done;
    int unsigned r;
    int unsigned pick;
    logic [63:0] a;
    in_word_t    w;
    done = 0;
    while (done < n_words) begin
      r = $urandom_range(99);
      if (!sb.tracking) begin
        w = word_of(2'($urandom_range(3)), rand64(), $urandom, rand64());
        if (r < 70) w.action = ACT_ENABLE;
        if (w.action == ACT_ENABLE || w.action == ACT_DISABLE) done++;
        send_word(w);
      end else begin
        done++;
        if (r < 3) begin
          send_action(ACT_DISABLE, rand64());
        end else if (r < 6) begin
          send_action(ACT_ENABLE, rand64());
        end else if (r < 10) begin
          send_action(ACT_FREE, rand64());
        end else if (sb.live == 0 || (sb.live < 40 ? r < 58 : r < 35)) begin
          pick = $urandom_range(9);
          if (sb.live > 0 && pick < 2)
            a = sb.addr_tbl[$urandom_range(sb.live - 1)];
          else if (pick == 2)
            a = ($urandom_range(1) != 0) ? '1 : '0;
          else
            a = rand64();
          send_action(ACT_ALLOC, a);
        end else begin
          send_action(ACT_FREE, sb.addr_tbl[$urandom_range(sb.live - 1)]);
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    wait_drained();
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      run_random(PHASE_WORDS);
      wait_drained();
    end
    repeat (SETTLE_TICKS) @(posedge clk);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: allocation_tracking_table.f
+incdir+hw/rtl
hw/rtl/att_pkg.sv
hw/rtl/att_cell.sv
hw/rtl/att_ctrl.sv
hw/rtl/allocation_tracking_table.sv
hw/rtl/att_checker.sv
dv/allocation_tracking_table_test.sv
